/* rtl/core/pwsr_pkg.sv */
// Shared types and constants for the pulse width serial receiver.
`timescale 1ns / 1ps

package pwsr_pkg;

    localparam int COUNT_WIDTH_DEF = 8;
    localparam int CFG_INDEX_W     = 3;
    localparam int BYTE_W          = 8;
    localparam int BIT_IDX_W       = 3;

    localparam logic [BYTE_W-1:0]    STOP_PATTERN = 8'h80;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;

    localparam logic [BYTE_W-1:0] ONE_LOW_MIN_RST     = 8'd12;
    localparam logic [BYTE_W-1:0] ONE_LOW_MAX_RST     = 8'd24;
    localparam logic [BYTE_W-1:0] ZERO_LOW_MIN_RST    = 8'd44;
    localparam logic [BYTE_W-1:0] ZERO_LOW_MAX_RST    = 8'd64;
    localparam logic [BYTE_W-1:0] IDLE_HIGH_LIMIT_RST = 8'd64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ONE_LOW_MIN     = 3'd0,
        REG_ONE_LOW_MAX     = 3'd1,
        REG_ZERO_LOW_MIN    = 3'd2,
        REG_ZERO_LOW_MAX    = 3'd3,
        REG_IDLE_HIGH_LIMIT = 3'd4
    } cfg_reg_index_t;

    typedef enum logic [1:0] {
        PH_WAIT      = 2'd0,
        PH_LOW       = 2'd1,
        PH_HIGH_GOOD = 2'd2,
        PH_HIGH_BAD  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_ERROR = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] one_low_min;
        logic [BYTE_W-1:0] one_low_max;
        logic [BYTE_W-1:0] zero_low_min;
        logic [BYTE_W-1:0] zero_low_max;
        logic [BYTE_W-1:0] idle_high_limit;
    } pwsr_cfg_t;

    typedef struct packed {
        logic              emit;
        result_kind_t      kind;
        logic [BYTE_W-1:0] data;
    } pwsr_result_t;

endpackage

/* rtl/core/pulse_width_serial_receiver_core.sv */
// A result appears on m_* the cycle after the sample that causes it.
// Throughput: one line sample per cycle; the single result register between
// the decoder and the m_ channel stalls input only while a result waits.
// Reset (aresetn low, synchronous) returns thresholds to their defaults,
// puts the decoder in wait-for-low and empties the result register.
`timescale 1ns / 1ps

module pulse_width_serial_receiver_core
    import pwsr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_line_level,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_result_kind,
    output logic [BYTE_W-1:0]      m_data_byte,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data
);

    pwsr_cfg_t    cfg;
    pwsr_result_t result;
    logic         take_ok;
    logic         s_xfer;

    assign s_ready = take_ok;
    assign s_xfer  = s_valid && take_ok;

    pwsr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwsr_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sample_en  (s_xfer),
        .line_level (s_line_level),
        .cfg        (cfg),
        .result     (result)
    );

    pwsr_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (s_xfer),
        .result        (result),
        .take_ok       (take_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_data_byte   (m_data_byte)
    );

endmodule

/* rtl/core/pwsr_cfg.sv */
// Configuration register file for the pulse width serial receiver.
`timescale 1ns / 1ps

module pwsr_cfg
    import pwsr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    output pwsr_cfg_t              cfg
);

    pwsr_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_low_min     <= ONE_LOW_MIN_RST;
            cfg_reg.one_low_max     <= ONE_LOW_MAX_RST;
            cfg_reg.zero_low_min    <= ZERO_LOW_MIN_RST;
            cfg_reg.zero_low_max    <= ZERO_LOW_MAX_RST;
            cfg_reg.idle_high_limit <= IDLE_HIGH_LIMIT_RST;
        end else if (cfg_valid) begin
            // indexes past the list are dropped
            case (cfg_index)
                REG_ONE_LOW_MIN:     cfg_reg.one_low_min     <= cfg_data;
                REG_ONE_LOW_MAX:     cfg_reg.one_low_max     <= cfg_data;
                REG_ZERO_LOW_MIN:    cfg_reg.zero_low_min    <= cfg_data;
                REG_ZERO_LOW_MAX:    cfg_reg.zero_low_max    <= cfg_data;
                REG_IDLE_HIGH_LIMIT: cfg_reg.idle_high_limit <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/pwsr_decode.sv */
// Pulse timing, bit classification and byte assembly state.
`timescale 1ns / 1ps

module pwsr_decode
    import pwsr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         sample_en,
    input  logic         line_level,
    input  pwsr_cfg_t    cfg,
    output pwsr_result_t result
);

    localparam int CMP_W = (COUNT_WIDTH > BYTE_W) ? COUNT_WIDTH : BYTE_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    phase_t                 phase_reg,     phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg,      tick_next;
    logic [BIT_IDX_W-1:0]   bit_idx_reg,   bit_idx_next;
    logic [BYTE_W-1:0]      shift_reg,     shift_next;
    logic                   err_reg,       err_next;
    logic                   last_bit_reg,  last_bit_next;

    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [CMP_W-1:0]       t_ext;
    logic [CMP_W-1:0]       one_min_ext, one_max_ext, zero_min_ext, zero_max_ext, idle_ext;
    logic                   is_one, is_zero;
    logic                   check_idle;
    logic                   good;

    assign tick_inc = (tick_reg == COUNT_MAX) ? tick_reg : tick_reg + COUNT_ONE;

    assign t_ext        = CMP_W'(tick_reg);
    assign one_min_ext  = CMP_W'(cfg.one_low_min);
    assign one_max_ext  = CMP_W'(cfg.one_low_max);
    assign zero_min_ext = CMP_W'(cfg.zero_low_min);
    assign zero_max_ext = CMP_W'(cfg.zero_low_max);
    assign idle_ext     = CMP_W'(cfg.idle_high_limit);

    assign is_one  = (one_min_ext <= t_ext) && (t_ext <= one_max_ext);
    assign is_zero = (zero_min_ext <= t_ext) && (t_ext <= zero_max_ext);

    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        err_next      = err_reg;
        last_bit_next = last_bit_reg;
        check_idle    = 1'b0;
        good          = 1'b0;
        result.emit   = 1'b0;
        result.kind   = KIND_DATA;
        result.data   = '0;

        unique case (phase_reg)
            PH_WAIT: begin
                if (!line_level) begin
                    phase_next = PH_LOW;
                    tick_next  = COUNT_ONE;
                end
            end
            PH_LOW: begin
                if (!line_level) begin
                    tick_next = tick_inc;
                end else begin
                    // a low inside both windows is a one
                    if (is_one) begin
                        shift_next    = shift_reg | (STOP_PATTERN >> bit_idx_reg);
                        last_bit_next = 1'b1;
                        phase_next    = PH_HIGH_GOOD;
                    end else if (is_zero) begin
                        last_bit_next = 1'b0;
                        phase_next    = PH_HIGH_GOOD;
                    end else begin
                        err_next   = 1'b1;
                        phase_next = PH_HIGH_BAD;
                    end
                    tick_next  = COUNT_ONE;
                    check_idle = 1'b1;
                end
            end
            PH_HIGH_GOOD, PH_HIGH_BAD: begin
                if (line_level) begin
                    tick_next  = tick_inc;
                    check_idle = 1'b1;
                end else begin
                    if (phase_reg == PH_HIGH_GOOD) begin
                        if (bit_idx_reg == LAST_BIT_IDX) begin
                            if (!err_reg) begin
                                result.emit = 1'b1;
                                result.kind = KIND_DATA;
                                result.data = shift_reg;
                            end
                            shift_next   = '0;
                            bit_idx_next = '0;
                        end else begin
                            bit_idx_next = bit_idx_reg + 1'b1;
                        end
                    end else begin
                        // drop the partial byte after a corrupt bit
                        shift_next   = '0;
                        bit_idx_next = '0;
                    end
                    phase_next = PH_LOW;
                    tick_next  = COUNT_ONE;
                end
            end
            default: ;
        endcase

        if (check_idle && (CMP_W'(tick_next) > idle_ext)) begin
            good = (phase_next == PH_HIGH_GOOD) && (bit_idx_next == '0) &&
                   last_bit_next && !err_next;
            result.emit   = 1'b1;
            result.kind   = good ? KIND_GOOD : KIND_ERROR;
            result.data   = '0;
            phase_next    = PH_WAIT;
            tick_next     = '0;
            bit_idx_next  = '0;
            shift_next    = '0;
            err_next      = 1'b0;
            last_bit_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WAIT;
            tick_reg     <= '0;
            bit_idx_reg  <= '0;
            shift_reg    <= '0;
            err_reg      <= 1'b0;
            last_bit_reg <= 1'b0;
        end else if (sample_en) begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            err_reg      <= err_next;
            last_bit_reg <= last_bit_next;
        end
    end

endmodule

/* rtl/core/pwsr_out.sv */
// Result register between the decoder and the result channel.
`timescale 1ns / 1ps

module pwsr_out
    import pwsr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  pwsr_result_t      result,
    output logic              take_ok,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_result_kind,
    output logic [BYTE_W-1:0] m_data_byte
);

    logic              valid_reg;
    result_kind_t      kind_reg;
    logic [BYTE_W-1:0] data_reg;

    // a new sample may enter when the slot is empty or drains this cycle
    assign take_ok       = !valid_reg || m_ready;
    assign m_valid       = valid_reg;
    assign m_result_kind = kind_reg;
    assign m_data_byte   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load && result.emit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.emit) begin
            kind_reg <= result.kind;
            data_reg <= result.data;
        end
    end

endmodule

/* sim/decode_check_pkg.sv */
// Scoreboard that predicts and checks the pulse width receiver's decoded results.
`timescale 1ns / 1ps

package decode_check_pkg;
    import pwsr_pkg::*;

    typedef struct {
        result_kind_t      kind;
        logic [BYTE_W-1:0] data;
    } decoded_result_t;

    class decode_scoreboard;
        pwsr_cfg_t                  cfg;
        phase_t                     ph;
        logic [COUNT_WIDTH_DEF-1:0] ticks;
        logic [BIT_IDX_W-1:0]       bit_idx;
        logic [BYTE_W-1:0]          shreg;
        logic                       pkt_bad;
        logic                       last_one;
        decoded_result_t            pending[$];
        int                         mismatches;
        int                         data_bytes;
        int                         good_packets;
        int                         error_packets;

        function new();
            cfg = '{one_low_min: ONE_LOW_MIN_RST, one_low_max: ONE_LOW_MAX_RST,
                    zero_low_min: ZERO_LOW_MIN_RST, zero_low_max: ZERO_LOW_MAX_RST,
                    idle_high_limit: IDLE_HIGH_LIMIT_RST};
            ph = PH_WAIT;
            ticks = '0;
            clear_packet();
            mismatches = 0;
            data_bytes = 0;
            good_packets = 0;
            error_packets = 0;
        endfunction

        function void set_threshold(cfg_reg_index_t idx, logic [BYTE_W-1:0] val);
            case (idx)
                REG_ONE_LOW_MIN:     cfg.one_low_min = val;
                REG_ONE_LOW_MAX:     cfg.one_low_max = val;
                REG_ZERO_LOW_MIN:    cfg.zero_low_min = val;
                REG_ZERO_LOW_MAX:    cfg.zero_low_max = val;
                REG_IDLE_HIGH_LIMIT: cfg.idle_high_limit = val;
                default: ;
            endcase
        endfunction

        function void clear_packet();
            bit_idx = '0;
            shreg = '0;
            pkt_bad = 1'b0;
            last_one = 1'b0;
        endfunction

        function void count_up();
            if (ticks != '1)
                ticks = ticks + 1'b1;
        endfunction

        // Close the packet once the high time passes the idle limit.
        function void end_on_idle();
            decoded_result_t r;
            if (ticks <= cfg.idle_high_limit)
                return;
            r.kind = (ph == PH_HIGH_GOOD && bit_idx == '0 && last_one && !pkt_bad) ?
                     KIND_GOOD : KIND_ERROR;
            r.data = '0;
            pending.push_back(r);
            clear_packet();
            ph = PH_WAIT;
            ticks = '0;
        endfunction

        // Advance the decoder by one accepted line sample.
        function void note_sample(logic line);
            decoded_result_t r;
            case (ph)
                PH_WAIT: begin
                    if (!line) begin
                        ph = PH_LOW;
                        ticks = COUNT_WIDTH_DEF'(1);
                    end
                end
                PH_LOW: begin
                    if (!line) begin
                        count_up();
                    end else begin
                        if (cfg.one_low_min <= ticks && ticks <= cfg.one_low_max) begin
                            shreg = shreg | (STOP_PATTERN >> bit_idx);
                            last_one = 1'b1;
                            ph = PH_HIGH_GOOD;
                        end else if (cfg.zero_low_min <= ticks &&
                                     ticks <= cfg.zero_low_max) begin
                            last_one = 1'b0;
                            ph = PH_HIGH_GOOD;
                        end else begin
                            pkt_bad = 1'b1;
                            ph = PH_HIGH_BAD;
                        end
                        ticks = COUNT_WIDTH_DEF'(1);
                        end_on_idle();
                    end
                end
                default: begin
                    if (line) begin
                        count_up();
                        end_on_idle();
                    end else begin
                        if (ph == PH_HIGH_GOOD) begin
                            if (bit_idx == LAST_BIT_IDX) begin
                                if (!pkt_bad) begin
                                    r.kind = KIND_DATA;
                                    r.data = shreg;
                                    pending.push_back(r);
                                end
                                shreg = '0;
                                bit_idx = '0;
                            end else begin
                                bit_idx = bit_idx + 1'b1;
                            end
                        end else begin
                            // drop the partial byte after a corrupt bit
                            shreg = '0;
                            bit_idx = '0;
                        end
                        ph = PH_LOW;
                        ticks = COUNT_WIDTH_DEF'(1);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [1:0] got_kind, logic [BYTE_W-1:0] got_data);
            decoded_result_t want;
            if (pending.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected result: kind %0d data %02h",
                             $time, got_kind, got_data);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got_kind !== want.kind || got_data !== want.data) begin
                if (mismatches < 10)
                    $display("[%0t] result mismatch: kind exp %0d got %0d, data exp %02h got %02h",
                             $time, want.kind, got_kind, want.data, got_data);
                mismatches++;
            end else begin
                case (want.kind)
                    KIND_DATA: data_bytes++;
                    KIND_GOOD: good_packets++;
                    default:   error_packets++;
                endcase
            end
        endfunction

        function void report_leftover();
            if (pending.size() != 0) begin
                $display("%0d expected results never arrived", pending.size());
                mismatches += pending.size();
            end
        endfunction
    endclass

endpackage

/* sim/tb_top.sv */
// Self-checking testbench top for the pulse width serial receiver core.
`timescale 1ns / 1ps

module tb_top;
    import pwsr_pkg::*;
    import decode_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum int {
        FLAW_NONE,
        FLAW_CORRUPT,
        FLAW_TRUNCATE,
        FLAW_NO_STOP,
        FLAW_NOISE
    } packet_flaw_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic                   s_line_level  = 1'b1;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [1:0]             m_result_kind;
    logic [BYTE_W-1:0]      m_data_byte;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [BYTE_W-1:0]      cfg_data      = '0;

    decode_scoreboard sb = new();
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int samples_sent  = 0;
    int settings_used = 0;
    int idle_cycles   = 0;

    pulse_width_serial_receiver_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_line_level  (s_line_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_data_byte   (m_data_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end

    // Check results and watch for a stalled run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_result_kind, m_data_byte);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("** pulse_width_serial_receiver_core: FAILED **");
                $finish;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
        end
    end

    task automatic send_sample(input logic lvl);
        @(negedge aclk);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_line_level = lvl;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(lvl);
        samples_sent++;
    endtask

    task automatic send_level(input logic lvl, input int n);
        repeat (n) send_sample(lvl);
    endtask

    task automatic write_threshold(input cfg_reg_index_t idx, input logic [BYTE_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_threshold(idx, val);
    endtask

    task automatic apply_setting(input logic [7:0] one_min, input logic [7:0] one_max,
                                 input logic [7:0] zero_min, input logic [7:0] zero_max,
                                 input logic [7:0] idle_lim);
        write_threshold(REG_ONE_LOW_MIN, one_min);
        write_threshold(REG_ONE_LOW_MAX, one_max);
        write_threshold(REG_ZERO_LOW_MIN, zero_min);
        write_threshold(REG_ZERO_LOW_MAX, zero_max);
        write_threshold(REG_IDLE_HIGH_LIMIT, idle_lim);
        @(negedge aclk);
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    // Hold the line high until the decoder is back at wait, then let every
    // result drain before thresholds change.
    task automatic settle();
        while (sb.ph != PH_WAIT)
            send_sample(1'b1);
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic int pick_len(input logic [7:0] mn, input logic [7:0] mx);
        int lo;
        int hi;
        lo = (mn == 0) ? 1 : int'(mn);
        hi = int'(mx);
        if (hi < lo)
            return $urandom_range(70, 1);
        if (hi - lo > 20 && $urandom_range(7, 0) != 0)
            hi = lo + 20;
        return $urandom_range(hi, lo);
    endfunction

    // Low length outside both bit windows, when one exists.
    function automatic int bad_len();
        int len;
        len = 1;
        repeat (20) begin
            len = $urandom_range(90, 1);
            if (!(len >= sb.cfg.one_low_min && len <= sb.cfg.one_low_max) &&
                !(len >= sb.cfg.zero_low_min && len <= sb.cfg.zero_low_max))
                return len;
        end
        return len;
    endfunction

    function automatic int gap_len();
        int cap;
        cap = (sb.cfg.idle_high_limit > 6) ? 6 : int'(sb.cfg.idle_high_limit);
        return (cap == 0) ? 1 : $urandom_range(cap, 1);
    endfunction

    function automatic int idle_len();
        return int'(sb.cfg.idle_high_limit) + $urandom_range(4, 1);
    endfunction

    task automatic send_bit(input logic b, input logic ends_packet);
        send_level(1'b0, b ? pick_len(sb.cfg.one_low_min, sb.cfg.one_low_max)
                           : pick_len(sb.cfg.zero_low_min, sb.cfg.zero_low_max));
        send_level(1'b1, ends_packet ? idle_len() : gap_len());
    endtask

    task automatic send_packet(input int nbytes, input packet_flaw_t flaw);
        int nbits;
        int flaw_at;
        int k;
        logic [7:0] data;
        nbits = nbytes * 8;
        flaw_at = $urandom_range(nbits, 0);
        data = '0;
        if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(12, 2))
                send_level(1'($urandom_range(1, 0)), $urandom_range(10, 1));
            send_level(1'b1, idle_len());
            return;
        end
        for (k = 0; k < nbits; k++) begin
            if (k % 8 == 0)
                data = 8'($urandom);
            if (flaw == FLAW_CORRUPT && k == flaw_at) begin
                send_level(1'b0, bad_len());
                send_level(1'b1, gap_len());
            end
            if (flaw == FLAW_TRUNCATE && k == flaw_at) begin
                send_level(1'b1, idle_len());
                return;
            end
            send_bit(data[7 - (k % 8)], 1'b0);
        end
        if (flaw == FLAW_NO_STOP)
            send_level(1'b1, idle_len());
        else
            send_bit(1'b1, 1'b1);
    endtask

    // Mostly well-formed packets, the rest damaged ones and line noise.
    task automatic run_random(input int budget, input int max_bytes);
        int stop_at;
        int pick;
        packet_flaw_t flaw;
        stop_at = samples_sent + budget;
        while (samples_sent < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
                flaw = FLAW_NONE;
            else if (pick < 78)
                flaw = FLAW_CORRUPT;
            else if (pick < 86)
                flaw = FLAW_TRUNCATE;
            else if (pick < 93)
                flaw = FLAW_NO_STOP;
            else
                flaw = FLAW_NOISE;
            send_packet($urandom_range(max_bytes, 0), flaw);
        end
        settle();
    endtask

    initial begin
        int k;
        src_idle_pct = 13;
        snk_idle_pct = 46;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Tightest windows: a one is a single low tick, a zero two, idle after one high tick.
        apply_setting(8'd1, 8'd1, 8'd2, 8'd2, 8'd1);
        // bytes 00 and FF then the stop bit; the very first sample is low
        for (k = 0; k < 16; k++) begin
            send_level(1'b0, (k < 8) ? 2 : 1);
            send_level(1'b1, 1);
        end
        send_level(1'b0, 1);
        send_level(1'b1, 2);
        // corrupt bit followed straight by idle
        send_level(1'b0, 3);
        send_level(1'b1, 2);
        // eight ones and then idle, no stop bit
        for (k = 0; k < 8; k++) begin
            send_level(1'b0, 1);
            send_level(1'b1, 1);
        end
        send_level(1'b1, 1);
        // idle in the middle of a byte
        send_level(1'b0, 1);
        send_level(1'b1, 1);
        send_level(1'b0, 2);
        send_level(1'b1, 1);
        send_level(1'b0, 1);
        send_level(1'b1, 2);
        settle();

        apply_setting(ONE_LOW_MIN_RST, ONE_LOW_MAX_RST, ZERO_LOW_MIN_RST,
                      ZERO_LOW_MAX_RST, IDLE_HIGH_LIMIT_RST);
        run_random(100, 1);
        apply_setting(8'd1, 8'd2, 8'd3, 8'd5, 8'd3);
        run_random(120, 3);

        src_idle_pct = 46;
        snk_idle_pct = 13;
        // overlapping windows: lows of 4 to 6 read as ones
        apply_setting(8'd2, 8'd6, 8'd4, 8'd8, 8'd5);
        run_random(100, 2);
        // inverted one window: only zeros decode
        apply_setting(8'd5, 8'd2, 8'd1, 8'd3, 8'd4);
        run_random(100, 2);
        // every low is a one; idle only on a saturated high count
        apply_setting(8'd0, 8'd255, 8'd255, 8'd0, 8'd254);
        run_random(1, 0);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        // only a saturated low is a one, and the first high tick is already idle
        apply_setting(8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        send_level(1'b0, 260);
        send_level(1'b1, 1);
        send_level(1'b0, 254);
        send_level(1'b1, 1);
        settle();
        apply_setting(8'd1, 8'd1, 8'd2, 8'd2, 8'd0);
        run_random(100, 1);
        apply_setting(8'd1, 8'd2, 8'd3, 8'd5, 8'd3);
        run_random(100, 3);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.report_leftover();
        $display("Covered %0d line samples under %0d threshold settings:", samples_sent,
                 settings_used);
        $display("  %0d bytes, %0d good and %0d errored packets matched, %0d mismatches",
                 sb.data_bytes, sb.good_packets, sb.error_packets, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("** pulse_width_serial_receiver_core: PASSED **");
        end else begin
            $display("** pulse_width_serial_receiver_core: FAILED **");
        end
        $finish;
    end

endmodule
